### src/apq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Array priority queue package
// Sizes, result status codes and the command and status types shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package apq_pkg;

    localparam int DEPTH    = 8;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int PRIO_W   = 16;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 4;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } apq_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } apq_stat_t;

endpackage

### src/apq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Carries one queue operation per transaction: mode, data and priority.
// ----------------------------------------------------------------------------
interface apq_req_if
    import apq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic signed [DATA_W-1:0] item_data;
    logic signed [PRIO_W-1:0] item_priority;

    modport source
    (
        output valid,
        output mode,
        output item_data,
        output item_priority,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  mode,
        input  item_data,
        input  item_priority,
        output ready
    );
endinterface

### src/apq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Carries one result per transaction: status, removed entry and fill level.
// ----------------------------------------------------------------------------
interface apq_rsp_if
    import apq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] out_data;
    logic signed [PRIO_W-1:0] out_priority;
    logic [FILL_W-1:0]        fill_count;

    modport source
    (
        output valid,
        output status,
        output out_data,
        output out_priority,
        output fill_count,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  status,
        input  out_data,
        input  out_priority,
        input  fill_count,
        output ready
    );
endinterface

### src/apq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Array priority queue datapath
// Entry array in arrival order, serial priority scan and result register.
// ----------------------------------------------------------------------------
module apq_datapath
    import apq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  apq_cmd_t                 cmd,
    output apq_stat_t                stat,
    input  logic                     mode,
    input  logic signed [DATA_W-1:0] item_data,
    input  logic signed [PRIO_W-1:0] item_priority,
    output logic [STATUS_W-1:0]      status,
    output logic signed [DATA_W-1:0] out_data,
    output logic signed [PRIO_W-1:0] out_priority,
    output logic [FILL_W-1:0]        fill_count
);

    logic signed [DATA_W-1:0] entry_data_reg  [DEPTH];
    logic signed [DATA_W-1:0] entry_data_next [DEPTH];
    logic signed [PRIO_W-1:0] entry_prio_reg  [DEPTH];
    logic signed [PRIO_W-1:0] entry_prio_next [DEPTH];
    logic [CNT_W-1:0]         fill_reg;
    logic [CNT_W-1:0]         fill_next;

    logic                     op_mode_reg;
    logic signed [DATA_W-1:0] op_data_reg;
    logic signed [PRIO_W-1:0] op_prio_reg;

    logic [IDX_W-1:0]         scan_idx_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic signed [PRIO_W-1:0] best_prio_reg;
    logic signed [DATA_W-1:0] best_data_reg;

    logic [STATUS_W-1:0]      status_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic signed [PRIO_W-1:0] out_prio_reg;
    logic [FILL_W-1:0]        fill_count_reg;

    logic [STATUS_W-1:0]      res_status;
    logic signed [DATA_W-1:0] res_data;
    logic signed [PRIO_W-1:0] res_prio;
    logic                     full;
    logic                     empty;
    logic                     better;

    assign full   = (fill_reg == CNT_W'(DEPTH));
    assign empty  = (fill_reg == '0);
    assign better = (entry_prio_reg[scan_idx_reg] > best_prio_reg);

    assign stat.need_scan = (mode == MODE_DEQ) && (fill_reg >= CNT_W'(2));
    assign stat.scan_last = (scan_idx_reg == IDX_W'(fill_reg - CNT_W'(1)));

    always_comb
    begin
        entry_data_next = entry_data_reg;
        entry_prio_next = entry_prio_reg;
        fill_next       = fill_reg;
        res_status      = ST_OK;
        res_data        = '0;
        res_prio        = '0;
        if (op_mode_reg == MODE_ENQ)
        begin
            if (full)
            begin
                res_status = ST_OVERFLOW;
            end
            else
            begin
                entry_data_next[fill_reg[IDX_W-1:0]] = op_data_reg;
                entry_prio_next[fill_reg[IDX_W-1:0]] = op_prio_reg;
                fill_next = fill_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                res_status = ST_UNDERFLOW;
            end
            else
            begin
                res_data = best_data_reg;
                res_prio = best_prio_reg;
                for (int j = 0; j < DEPTH - 1; j++)
                begin
                    if ((IDX_W'(j) >= best_idx_reg) && (CNT_W'(j + 1) < fill_reg))
                    begin
                        entry_data_next[j] = entry_data_reg[j + 1];
                        entry_prio_next[j] = entry_prio_reg[j + 1];
                    end
                end
                fill_next = fill_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cmd.commit)
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            entry_data_reg <= entry_data_next;
            entry_prio_reg <= entry_prio_next;
            status_reg     <= res_status;
            out_data_reg   <= res_data;
            out_prio_reg   <= res_prio;
            fill_count_reg <= FILL_W'(fill_next);
        end
        if (cmd.load)
        begin
            op_mode_reg   <= mode;
            op_data_reg   <= item_data;
            op_prio_reg   <= item_priority;
            scan_idx_reg  <= IDX_W'(1);
            best_idx_reg  <= '0;
            best_prio_reg <= entry_prio_reg[0];
            best_data_reg <= entry_data_reg[0];
        end
        else if (cmd.step)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            if (better)
            begin
                best_idx_reg  <= scan_idx_reg;
                best_prio_reg <= entry_prio_reg[scan_idx_reg];
                best_data_reg <= entry_data_reg[scan_idx_reg];
            end
        end
    end

    assign status       = status_reg;
    assign out_data     = out_data_reg;
    assign out_priority = out_prio_reg;
    assign fill_count   = fill_count_reg;

endmodule

### src/apq_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Array priority queue controller
// Sequences accept, priority scan and commit, and owns the result valid flag.
// ----------------------------------------------------------------------------
module apq_controller
    import apq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  apq_stat_t stat,
    output apq_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.need_scan ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("Commit did not raise the result valid flag.");

    a_commit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("Commit overwrote a result that was not yet taken.");

    a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_SCAN || state_reg == S_FINISH))
        else $error("Accepted transaction did not start processing.");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && stat.scan_last) |=> (state_reg == S_FINISH))
        else $error("Priority scan did not stop at the last entry.");

endmodule

### src/array_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Array priority queue
// Bounded queue of (data, priority) entries in arrival order; dequeue removes
// the earliest entry of greatest priority and closes the gap.
// A request transaction is loaded in the idle state; a dequeue from a queue
// holding n >= 2 entries then passes through the scan state, where the single
// priority comparator visits one held entry per cycle. The result is committed
// in the finish state once the previous response transaction no longer waits
// on rsp.ready. A new request transaction is accepted only in the idle state.
// Reset clears the fill level and the result valid flag; entries are not reset.
// ----------------------------------------------------------------------------
module array_priority_queue
    import apq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    apq_req_if.sink   req,
    apq_rsp_if.source rsp
);

    apq_cmd_t  cmd;
    apq_stat_t stat;

    apq_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    apq_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .mode          (req.mode),
        .item_data     (req.item_data),
        .item_priority (req.item_priority),
        .status        (rsp.status),
        .out_data      (rsp.out_data),
        .out_priority  (rsp.out_priority),
        .fill_count    (rsp.fill_count)
    );

endmodule

### bench/array_priority_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Array priority queue testbench
// Runs a short directed table through the queue: empty and full conditions,
// data and priority extremes, and ties. Random enqueue and dequeue traffic
// follows, with varying fill pressure and random gaps on both channels. Each
// response is checked against its typed row or an in-bench queue predictor.
// ----------------------------------------------------------------------------
module array_priority_queue_test;
    import apq_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 500;
    localparam int SEGMENT_LEN  = 50;
    localparam int DRAIN_CYCLES = DEPTH + 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int ROWS         = 25;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data;
        logic [PRIO_W-1:0]   prio;
        logic [FILL_W-1:0]   fill;
    } queue_result_t;

    typedef struct packed {
        bit                typed;
        logic              mode;
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
        queue_result_t     result;
    } op_row_t;

    localparam op_row_t DIRECTED [ROWS] = '{
        '{1'b1, MODE_DEQ, 32'h0000_0000, 16'h0000, '{ST_UNDERFLOW, 32'h0, 16'h0, 4'd0}},
        '{1'b1, MODE_ENQ, 32'h7FFF_FFFF, 16'h7FFF, '{ST_OK, 32'h0, 16'h0, 4'd1}},
        '{1'b1, MODE_DEQ, 32'h0000_0000, 16'h0000, '{ST_OK, 32'h7FFF_FFFF, 16'h7FFF, 4'd0}},
        '{1'b1, MODE_ENQ, 32'h8000_0000, 16'h8000, '{ST_OK, 32'h0, 16'h0, 4'd1}},
        '{1'b1, MODE_ENQ, 32'hFFFF_FFFF, 16'h8000, '{ST_OK, 32'h0, 16'h0, 4'd2}},
        '{1'b1, MODE_DEQ, 32'hFFFF_FFFF, 16'hFFFF, '{ST_OK, 32'h8000_0000, 16'h8000, 4'd1}},
        '{1'b1, MODE_DEQ, 32'h0000_0000, 16'h0000, '{ST_OK, 32'hFFFF_FFFF, 16'h8000, 4'd0}},
        '{1'b0, MODE_ENQ, 32'h1111_1111, 16'h0005, '0},
        '{1'b0, MODE_ENQ, 32'h2222_2222, 16'hFFFD, '0},
        '{1'b0, MODE_ENQ, 32'h3333_3333, 16'h0005, '0},
        '{1'b0, MODE_ENQ, 32'h4444_4444, 16'h0064, '0},
        '{1'b0, MODE_ENQ, 32'h5555_5555, 16'h0000, '0},
        '{1'b0, MODE_ENQ, 32'h6666_6666, 16'h0064, '0},
        '{1'b0, MODE_ENQ, 32'h7777_7777, 16'h8000, '0},
        '{1'b0, MODE_ENQ, 32'h8888_8888, 16'h7FFF, '0},
        '{1'b1, MODE_ENQ, 32'hA5A5_A5A5, 16'h1234, '{ST_OVERFLOW, 32'h0, 16'h0, 4'd8}},
        '{1'b0, MODE_DEQ, 32'h0000_0000, 16'h0000, '0},
        '{1'b0, MODE_DEQ, 32'h0000_0000, 16'h0000, '0},
        '{1'b0, MODE_DEQ, 32'h0000_0000, 16'h0000, '0},
        '{1'b0, MODE_DEQ, 32'h0000_0000, 16'h0000, '0},
        '{1'b0, MODE_DEQ, 32'h0000_0000, 16'h0000, '0},
        '{1'b0, MODE_DEQ, 32'h0000_0000, 16'h0000, '0},
        '{1'b0, MODE_DEQ, 32'h0000_0000, 16'h0000, '0},
        '{1'b0, MODE_DEQ, 32'h0000_0000, 16'h0000, '0},
        '{1'b1, MODE_DEQ, 32'h0000_0000, 16'h0000, '{ST_UNDERFLOW, 32'h0, 16'h0, 4'd0}}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    apq_req_if req_ch ();
    apq_rsp_if rsp_ch ();

    array_priority_queue uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [DATA_W-1:0]        held_data [DEPTH];
    logic signed [PRIO_W-1:0] held_prio [DEPTH];
    int                       held_count = 0;
    queue_result_t            awaited_results [$];
    int                       error_count = 0;
    int                       cycle_count = 0;
    bit                       no_idle = 1'b0;

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("array_priority_queue test failed");
            $finish;
        end
    end

    function automatic queue_result_t apply_queue_op(logic mode, logic [DATA_W-1:0] data,
                                                     logic [PRIO_W-1:0] prio);
        queue_result_t res;
        int            best;
        res = '0;
        if (mode == MODE_ENQ)
        begin
            if (held_count >= DEPTH)
                res.status = ST_OVERFLOW;
            else
            begin
                held_data[held_count] = data;
                held_prio[held_count] = prio;
                held_count++;
            end
        end
        else if (held_count == 0)
            res.status = ST_UNDERFLOW;
        else
        begin
            best = 0;
            for (int i = 1; i < held_count; i++)
                if (held_prio[i] > held_prio[best])
                    best = i;
            res.data = held_data[best];
            res.prio = held_prio[best];
            for (int i = best; i < held_count - 1; i++)
            begin
                held_data[i] = held_data[i + 1];
                held_prio[i] = held_prio[i + 1];
            end
            held_count--;
        end
        res.fill = FILL_W'(held_count);
        return res;
    endfunction

    task automatic issue_op(logic mode, logic [DATA_W-1:0] data, logic [PRIO_W-1:0] prio,
                            bit typed, queue_result_t typed_result);
        int            gap;
        queue_result_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.mode          <= mode;
        req_ch.item_data     <= data;
        req_ch.item_priority <= prio;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = apply_queue_op(mode, data, prio);
        awaited_results.push_back(typed ? typed_result : predicted);
    endtask

    function automatic logic [PRIO_W-1:0] random_priority();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return PRIO_W'($urandom_range(0, 6) - 3);
        else if (pick < 7)
            return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        else
            return PRIO_W'($urandom);
    endfunction

    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            int            gap;
            queue_result_t expected;
            gap = no_idle ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected transaction, status %0d data %0d priority %0d fill %0d",
                         $time, rsp_ch.status, rsp_ch.out_data, rsp_ch.out_priority,
                         rsp_ch.fill_count);
                error_count++;
            end
            else
            begin
                expected = awaited_results.pop_front();
                if (rsp_ch.status !== expected.status)
                begin
                    $display("%0t: status expected %0d, actual %0d",
                             $time, expected.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.out_data !== expected.data)
                begin
                    $display("%0t: out_data expected %0d, actual %0d",
                             $time, $signed(expected.data), rsp_ch.out_data);
                    error_count++;
                end
                if (rsp_ch.out_priority !== expected.prio)
                begin
                    $display("%0t: out_priority expected %0d, actual %0d",
                             $time, $signed(expected.prio), rsp_ch.out_priority);
                    error_count++;
                end
                if (rsp_ch.fill_count !== expected.fill)
                begin
                    $display("%0t: fill_count expected %0d, actual %0d",
                             $time, expected.fill, rsp_ch.fill_count);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int enq_percent;
        int drain_wait;
        req_ch.valid         = 1'b0;
        req_ch.mode          = MODE_ENQ;
        req_ch.item_data     = '0;
        req_ch.item_priority = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < ROWS; r++)
            issue_op(DIRECTED[r].mode, DIRECTED[r].data, DIRECTED[r].prio,
                     DIRECTED[r].typed, DIRECTED[r].result);

        enq_percent = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % SEGMENT_LEN == 0)
            begin
                case ($urandom_range(0, 4))
                    0: enq_percent = 85;
                    1: enq_percent = 15;
                    2: enq_percent = 50;
                    3: enq_percent = 65;
                    default: enq_percent = 35;
                endcase
                no_idle = ($urandom_range(0, 3) == 0);
            end
            issue_op(($urandom_range(0, 99) < enq_percent) ? MODE_ENQ : MODE_DEQ,
                     $urandom, random_priority(), 1'b0, '0);
        end
        req_ch.valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("array_priority_queue test passed");
        else
            $display("array_priority_queue test failed");
        $finish;
    end

endmodule
